FILE: hdl/assert_macros.svh
// Assertion macros for the indexed_stack_engine RTL.
// Needs a signal named clock and a signal named reset in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset
`define ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off during reset
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/ise_pkg.sv
// Types and codes for the indexed stack engine.
// No dependencies; used by ise_cell and indexed_stack_engine.
package ise_pkg;

   typedef struct packed {
      logic [3:0]          operation;
      logic signed [31:0]  value;
      logic [4:0]          index;
   } req_type;

   typedef struct packed {
      logic signed [31:0]  result_value;
      logic                found;
      logic [4:0]          entry_count;
      logic [1:0]          status;
   } rsp_type;

   typedef enum logic [3:0] {
      OP_PUSH    = 4'd0,
      OP_POP     = 4'd1,
      OP_PEEK    = 4'd2,
      OP_READ    = 4'd3,
      OP_REMOVE  = 4'd4,
      OP_FIND    = 4'd5,
      OP_CHANGE  = 4'd6,
      OP_INSERT  = 4'd7,
      OP_REVERSE = 4'd8,
      OP_SORT    = 4'd9,
      OP_STRIDE  = 4'd10,
      OP_LENGTH  = 4'd11,
      OP_CLEAR   = 4'd12
   } op_type;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   // Command that tells every cell what to do
   typedef enum logic [3:0] {
      CM_HOLD,
      CM_SHIFT_IN,   // positions past idx take from above, idx loads value
      CM_SHIFT_OUT,  // positions from idx on take from below
      CM_WRITE,      // position idx loads value
      CM_ROTATE,     // every cell takes from below, the top wraps to the last
      CM_TAG,        // tag gets own position
      CM_SORT,       // compare-exchange on values
      CM_REVERSE     // compare-exchange on tags
   } cell_mode_type;

   typedef struct packed {
      cell_mode_type       mode;
      logic                phase;
      logic signed [31:0]  value;
   } cell_ctl_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_ROTATE,
      S_CSWAP,
      S_FINISH
   } state_type;

endpackage

FILE: hdl/indexed_stack_engine.sv
// Indexed stack engine top level: control sequencer over a chain of cells.
// Depends on ise_pkg, ise_cell and assert_macros.svh.
//
//   port group   dir   flow control        contents
//   req_*        in    req_valid/stall     operation, value, index
//   rsp_*        out   rsp_valid/stall     result_value, found, entry_count, status
//
// Push, pop, peek, remove, change, insert, length, clear: result in the next cycle.
// Read, find, stride sum: one full rotation of the chain in S_ROTATE, then S_FINISH.
// Sort, reverse: DEPTH odd-even exchange rounds in S_CSWAP, then S_FINISH.
// Synchronous reset empties the stack; entry words are not cleared.
// A result waits in the output register; a transfer is taken in S_IDLE once it is free.
`include "assert_macros.svh"

module indexed_stack_engine #(
   parameter int DEPTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ise_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ise_pkg::rsp_type rsp_data
);
   import ise_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);
   localparam int IW = (CW > 5) ? CW : 5;
   localparam int PW = $clog2(DEPTH);

   state_type           state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       step_ff, step_in;
   logic [4:0]          sc_ff, sc_in;
   op_type              op_ff, op_in;
   logic [4:0]          idx_ff, idx_in;
   logic signed [31:0]  value_ff, value_in;
   logic signed [31:0]  acc_ff, acc_in;
   logic                found_ff, found_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;

   cell_ctl_type        ctl;
   logic [IW-1:0]       cell_idx;
   logic [IW-1:0]       count_x, idx_x, step_x;
   logic                accept, rsp_free, full;
   op_type              op;

   logic signed [31:0]  val_w [DEPTH];
   logic [PW-1:0]       tag_w [DEPTH];
   logic                lt_w  [DEPTH];

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE) || !rsp_free;
   assign accept    = req_valid && !req_stall;
   assign op        = op_type'(req_data.operation);
   assign count_x   = IW'(count_ff);
   assign idx_x     = IW'(req_data.index);
   assign step_x    = IW'(step_ff);
   assign full      = count_ff == CW'(DEPTH);

   // Cell chain, position 0 is the top of the stack
   for (genvar k = 0; k < DEPTH; k++) begin : g_cell
      localparam int KU = (k == 0) ? DEPTH - 1 : k - 1;
      localparam int KD = (k == DEPTH - 1) ? 0 : k + 1;
      ise_cell #(.DEPTH(DEPTH)) u_cell (
         .clock    (clock),
         .ctl      (ctl),
         .pos_in   (IW'(k)),
         .idx_in   (cell_idx),
         .count_in (count_x),
         .up_val   (val_w[KU]),
         .up_tag   (tag_w[KU]),
         .up_lt    ((k == 0) ? 1'b0 : lt_w[KU]),
         .down_val (val_w[KD]),
         .down_tag (tag_w[KD]),
         .val_out  (val_w[k]),
         .tag_out  (tag_w[k]),
         .lt_out   (lt_w[k])
      );
   end

   // Sequencer: next state, cell command and result
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      step_in      = step_ff;
      sc_in        = sc_ff;
      op_in        = op_ff;
      idx_in       = idx_ff;
      value_in     = value_ff;
      acc_in       = acc_ff;
      found_in     = found_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      ctl.mode     = CM_HOLD;
      ctl.phase    = step_ff[0];
      ctl.value    = req_data.value;
      cell_idx     = idx_x;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_data_in.result_value = '0;
               rsp_data_in.found        = 1'b0;
               rsp_data_in.status       = ST_OK;
               op_in    = op;
               idx_in   = req_data.index;
               value_in = req_data.value;
               acc_in   = '0;
               found_in = 1'b0;
               sc_in    = '0;
               step_in  = '0;
               rsp_valid_in = 1'b1;
               unique case (op)
                  OP_PUSH: begin
                     if (full) begin
                        rsp_data_in.status = ST_FULL;
                     end else begin
                        ctl.mode = CM_SHIFT_IN;
                        cell_idx = '0;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  OP_POP: begin
                     if (count_ff == '0) begin
                        rsp_data_in.status = ST_RANGE;
                     end else begin
                        rsp_data_in.result_value = val_w[0];
                        ctl.mode = CM_SHIFT_OUT;
                        cell_idx = '0;
                        count_in = count_ff - 1'b1;
                     end
                  end
                  OP_PEEK: begin
                     if (count_ff == '0) begin
                        rsp_data_in.status = ST_RANGE;
                     end else begin
                        rsp_data_in.result_value = val_w[0];
                     end
                  end
                  OP_READ: begin
                     if (idx_x >= count_x) begin
                        rsp_data_in.status = ST_RANGE;
                     end else begin
                        rsp_valid_in = rsp_valid_ff && rsp_stall;
                        state_in     = S_ROTATE;
                     end
                  end
                  OP_REMOVE: begin
                     if (idx_x >= count_x) begin
                        rsp_data_in.status = ST_RANGE;
                     end else begin
                        ctl.mode = CM_SHIFT_OUT;
                        count_in = count_ff - 1'b1;
                     end
                  end
                  OP_CHANGE: begin
                     if (idx_x >= count_x) begin
                        rsp_data_in.status = ST_RANGE;
                     end else begin
                        ctl.mode = CM_WRITE;
                     end
                  end
                  OP_INSERT: begin
                     if (idx_x > count_x) begin
                        rsp_data_in.status = ST_RANGE;
                     end else if (full) begin
                        rsp_data_in.status = ST_FULL;
                     end else begin
                        ctl.mode = CM_SHIFT_IN;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  OP_FIND, OP_STRIDE: begin
                     rsp_valid_in = rsp_valid_ff && rsp_stall;
                     state_in     = S_ROTATE;
                  end
                  OP_REVERSE: begin
                     ctl.mode     = CM_TAG;
                     rsp_valid_in = rsp_valid_ff && rsp_stall;
                     state_in     = S_CSWAP;
                  end
                  OP_SORT: begin
                     rsp_valid_in = rsp_valid_ff && rsp_stall;
                     state_in     = S_CSWAP;
                  end
                  OP_CLEAR: count_in = '0;
                  default: ;
               endcase
               rsp_data_in.entry_count = 5'(count_in);
            end
         end
         S_ROTATE: begin
            ctl.mode = CM_ROTATE;
            if (step_x < count_x) begin
               unique case (op_ff)
                  OP_FIND: begin
                     if (val_w[0] == value_ff) begin
                        found_in = 1'b1;
                     end
                  end
                  OP_READ: begin
                     if (step_x == IW'(idx_ff)) begin
                        acc_in = val_w[0];
                     end
                  end
                  OP_STRIDE: begin
                     if (sc_ff == '0) begin
                        acc_in = acc_ff + val_w[0];
                     end
                     sc_in = (sc_ff == idx_ff) ? 5'd0 : sc_ff + 5'd1;
                  end
                  default: ;
               endcase
            end
            step_in = step_ff + 1'b1;
            if (step_ff == CW'(DEPTH - 1)) begin
               state_in = S_FINISH;
            end
         end
         S_CSWAP: begin
            ctl.mode = (op_ff == OP_REVERSE) ? CM_REVERSE : CM_SORT;
            step_in  = step_ff + 1'b1;
            if (step_ff == CW'(DEPTH - 1)) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (rsp_free) begin
               rsp_data_in.result_value = acc_ff;
               rsp_data_in.found        = found_ff;
               rsp_data_in.entry_count  = 5'(count_ff);
               rsp_data_in.status       = ST_OK;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working and result registers
   always_ff @(posedge clock) begin
      step_ff     <= step_in;
      sc_ff       <= sc_in;
      op_ff       <= op_in;
      idx_ff      <= idx_in;
      value_ff    <= value_in;
      acc_ff      <= acc_in;
      found_ff    <= found_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `ASSERT_IMPL(a_count_bound, 1'b1, count_ff <= CW'(DEPTH), "entry count above depth")
   `ASSERT_NEXT(a_rotate_end, state_ff == S_ROTATE && step_ff == CW'(DEPTH - 1), state_ff == S_FINISH, "rotation did not end after depth steps")
   `ASSERT_NEXT(a_full_push, accept && op == OP_PUSH && full, count_ff == CW'(DEPTH) && rsp_data_ff.status == ST_FULL, "push on full stack changed count")

endmodule

FILE: hdl/ise_cell.sv
// One stack position: entry word, order tag and neighbor exchange logic.
// Depends on ise_pkg.
module ise_cell #(
   parameter int DEPTH = 16
) (
   input  logic                               clock,
   input  ise_pkg::cell_ctl_type              ctl,
   input  logic [((($clog2(DEPTH+1)) > 5) ? $clog2(DEPTH+1) : 5)-1:0] pos_in,
   input  logic [((($clog2(DEPTH+1)) > 5) ? $clog2(DEPTH+1) : 5)-1:0] idx_in,
   input  logic [((($clog2(DEPTH+1)) > 5) ? $clog2(DEPTH+1) : 5)-1:0] count_in,
   input  logic signed [31:0]                 up_val,
   input  logic [$clog2(DEPTH)-1:0]           up_tag,
   input  logic                               up_lt,
   input  logic signed [31:0]                 down_val,
   input  logic [$clog2(DEPTH)-1:0]           down_tag,
   output logic signed [31:0]                 val_out,
   output logic [$clog2(DEPTH)-1:0]           tag_out,
   output logic                               lt_out
);
   import ise_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);
   localparam int IW = (CW > 5) ? CW : 5;
   localparam int PW = $clog2(DEPTH);

   logic signed [31:0] val_ff, val_in;
   logic [PW-1:0]      tag_ff, tag_in;
   logic               upper, lower;
   logic [IW-1:0]      pos_next;

   assign pos_next = pos_in + 1'b1;

   // Pair roles for the current exchange phase
   assign upper = (pos_in[0] == ctl.phase) && (pos_next < count_in);
   assign lower = (pos_in[0] != ctl.phase) && (pos_in != '0) && (pos_in < count_in);

   // Upper member swaps when its key is below the one underneath
   always_comb begin
      if (ctl.mode == CM_REVERSE) begin
         lt_out = tag_ff < down_tag;
      end else begin
         lt_out = val_ff < down_val;
      end
   end

   always_comb begin
      val_in = val_ff;
      tag_in = tag_ff;
      unique case (ctl.mode)
         CM_SHIFT_IN: begin
            if (pos_in > idx_in) begin
               val_in = up_val;
            end else if (pos_in == idx_in) begin
               val_in = ctl.value;
            end
         end
         CM_SHIFT_OUT: begin
            if (pos_in >= idx_in) begin
               val_in = down_val;
            end
         end
         CM_WRITE: begin
            if (pos_in == idx_in) begin
               val_in = ctl.value;
            end
         end
         CM_ROTATE: val_in = down_val;
         CM_TAG:    tag_in = pos_in[PW-1:0];
         CM_SORT, CM_REVERSE: begin
            if (upper && lt_out) begin
               val_in = down_val;
               tag_in = down_tag;
            end else if (lower && up_lt) begin
               val_in = up_val;
               tag_in = up_tag;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
      tag_ff <= tag_in;
   end

   assign val_out = val_ff;
   assign tag_out = tag_ff;

endmodule
